// ===== rtl/wms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types, codes and helpers of the windowed mailbox slot manager.
// ----------------------------------------------------------------------------
package wms_pkg;

    localparam int CNT_W = 7;  // holds window and group sizes up to 64

    localparam logic [2:0] KIND_LANDED    = 3'd0;
    localparam logic [2:0] KIND_PROBE     = 3'd1;
    localparam logic [2:0] KIND_PROBE_ALL = 3'd2;
    localparam logic [2:0] KIND_RESERVE   = 3'd3;
    localparam logic [2:0] KIND_SEND      = 3'd4;

    localparam logic [1:0] CLS_REQ  = 2'd0;
    localparam logic [1:0] CLS_PEER = 2'd1;
    localparam logic [1:0] CLS_RPC  = 2'd2;
    localparam logic [1:0] CLS_BAD  = 2'd3;

    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_SLOTB  = 2'd1;
    localparam logic [1:0] CFG_RANK   = 2'd2;
    localparam logic [1:0] CFG_PEERS  = 2'd3;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_NONE = 1'b1;

    typedef enum logic [2:0] {
        OP_FAIL, OP_LAND, OP_PROBE, OP_PROBE_ALL, OP_RESERVE, OP_SEND
    } t_op;

    typedef enum logic [3:0] {
        BS_CLEAR, BS_IDLE, BS_EXEC, BS_SCAN, BS_RD, BS_MODS, BS_MODW,
        BS_TRD, BS_TCHK, BS_MUL, BS_EMIT
    } t_bstate;

    typedef struct packed {
        logic [4:0]  window_slots;
        logic [20:0] slot_bytes;
        logic [3:0]  own_rank;
        logic [4:0]  peer_count;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [3:0]  peer;
        logic [1:0]  cls;
        logic [3:0]  slot;
        logic [31:0] seq;
    } t_cmd;

    typedef struct packed {
        logic        status;
        logic [3:0]  peer_out;
        logic [1:0]  class_out;
        logic [25:0] byte_offset;
        logic [31:0] trailer_value;
        logic [20:0] write_length;
    } t_res;

    function automatic logic [CNT_W-1:0] eff_window(input logic [4:0] ws,
                                                    input logic [CNT_W-1:0] mw);
        logic [CNT_W-1:0] t;
        t = CNT_W'(ws);
        if (t == '0) return CNT_W'(1);
        if (t > mw) return mw;
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] eff_peers(input logic [4:0] pc,
                                                   input logic [CNT_W-1:0] mp);
        logic [CNT_W-1:0] t;
        t = CNT_W'(pc);
        return (t > mp) ? mp : t;
    endfunction

    function automatic t_res fail_res(input logic [3:0] p, input logic [1:0] c);
        t_res r;
        r = '0;
        r.status    = ST_NONE;
        r.peer_out  = p;
        r.class_out = c;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/wms_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module wms_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) r_cnt <= r_cnt + (AW+1)'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

// ===== rtl/wms_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_front
// Classify an incoming item into a command; reject bad peers and slots.
// ----------------------------------------------------------------------------
module wms_front #(
    parameter int MAX_PEERS  = 16,
    parameter int MAX_WINDOW = 16
) (
    input  wire wms_pkg::t_cfg i_cfg,
    input  wire logic [2:0]    i_kind,
    input  wire logic [3:0]    i_peer,
    input  wire logic [1:0]    i_msg_class,
    input  wire logic [3:0]    i_slot,
    input  wire logic [31:0]   i_seq_value,
    output wms_pkg::t_cmd      o_cmd
);
    import wms_pkg::*;

    logic [CNT_W-1:0] w_eff, n_eff;
    logic             peer_ok;

    assign w_eff   = eff_window(i_cfg.window_slots, CNT_W'(MAX_WINDOW));
    assign n_eff   = eff_peers(i_cfg.peer_count, CNT_W'(MAX_PEERS));
    assign peer_ok = CNT_W'(i_peer) < n_eff;

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = OP_FAIL;
        o_cmd.peer = i_peer;
        o_cmd.cls  = i_msg_class;
        o_cmd.slot = i_slot;
        o_cmd.seq  = i_seq_value;
        case (i_kind)
            KIND_LANDED: begin
                if (peer_ok && i_msg_class != CLS_BAD && CNT_W'(i_slot) < w_eff)
                    o_cmd.op = OP_LAND;
            end
            KIND_PROBE: begin
                if (peer_ok) o_cmd.op = OP_PROBE;
                else o_cmd.cls = CLS_REQ;
            end
            KIND_PROBE_ALL: begin
                o_cmd.op = OP_PROBE_ALL;
            end
            KIND_RESERVE: begin
                if (peer_ok) begin
                    o_cmd.op = OP_RESERVE;
                    if (i_msg_class == CLS_BAD) o_cmd.cls = CLS_REQ;
                end
            end
            KIND_SEND: begin
                if (peer_ok) o_cmd.op = OP_SEND;
            end
            default: begin
                o_cmd.peer = '0;
                o_cmd.cls  = CLS_REQ;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/wms_rem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_rem
// Remainder of a 32-bit sequence number by the window, one bit per cycle.
// ----------------------------------------------------------------------------
module wms_rem (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_x,
    input  wire logic [6:0]  i_w,
    output logic             o_done,
    output logic [6:0]       o_rem
);
    logic [31:0] r_x;
    logic [6:0]  r_r;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [7:0]  t;

    assign t      = {r_r, r_x[31]};
    assign o_done = r_done;
    assign o_rem  = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_r <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[30:0], 1'b0};
            r_r <= (t >= {1'b0, i_w}) ? 7'(t - {1'b0, i_w}) : 7'(t);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wms_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wms_back
// Command executor: sequence counters, trailer store, probe scan, offsets.
// ----------------------------------------------------------------------------
module wms_back #(
    parameter int MAX_PEERS  = 16,
    parameter int MAX_WINDOW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire wms_pkg::t_cfg i_cfg,
    input  wire wms_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output wms_pkg::t_res      o_res,
    output logic               o_clearing
);
    import wms_pkg::*;

    localparam int SEQ_DEPTH = 3 * MAX_PEERS;
    localparam int SA_W      = $clog2(SEQ_DEPTH);
    localparam int TR_DEPTH  = SEQ_DEPTH * MAX_WINDOW;
    localparam int TA_W      = $clog2(TR_DEPTH);
    localparam int PW        = $clog2(MAX_PEERS);
    localparam int PC_W      = PW + 1;
    localparam int PEND_N    = (MAX_PEERS < 16) ? MAX_PEERS : 16;
    localparam int PN_W      = $clog2(PEND_N);

    function automatic logic [SA_W-1:0] row_of(input logic [PW-1:0] p,
                                               input logic [1:0] c);
        logic [SA_W+1:0] t;
        t = (SA_W+2)'(p) * (SA_W+2)'(3) + (SA_W+2)'(c);
        return t[SA_W-1:0];
    endfunction

    function automatic logic [TA_W-1:0] tr_addr(input logic [SA_W-1:0] r,
                                                input logic [CNT_W-1:0] i);
        logic [TA_W+CNT_W:0] t;
        t = (TA_W+CNT_W+1)'(r) * (TA_W+CNT_W+1)'(MAX_WINDOW) + (TA_W+CNT_W+1)'(i);
        return t[TA_W-1:0];
    endfunction

    // memories
    logic [31:0] r_in_mem  [SEQ_DEPTH];
    logic [31:0] r_out_mem [SEQ_DEPTH];
    logic [31:0] r_tr_mem  [TR_DEPTH];
    logic [31:0] r_in_rd, r_out_rd, r_tr_rd;
    logic [SA_W-1:0] in_raddr, out_raddr, in_waddr, out_waddr;
    logic [TA_W-1:0] tr_raddr, tr_waddr;
    logic [31:0]     in_wdata, out_wdata, tr_wdata;
    logic            in_we, out_we, tr_we;

    // control and datapath registers
    t_bstate          r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [PC_W-1:0]  r_peer, n_peer;
    logic [1:0]       r_cls, n_cls;
    logic [31:0]      r_seq, n_seq;
    logic [CNT_W-1:0] r_idx, n_idx;
    t_res             r_res, n_res;
    logic [TA_W-1:0]  r_clr;
    logic [1:0]       r_pend [PEND_N];
    logic             pend_we;

    logic [CNT_W-1:0] w_eff, n_eff;
    logic [PW-1:0]    pk;
    logic [SA_W-1:0]  cur_row;
    logic             is_probe, clr_last, scan_end, scan_skip, win_fail, tr_hit;
    logic [31:0]      mod_x, win_d, seq_inc;
    logic             rem_start, rem_done;
    logic [6:0]       rem_val;
    logic [7:0]       base;
    logic [28:0]      prod;

    assign w_eff    = eff_window(i_cfg.window_slots, CNT_W'(MAX_WINDOW));
    assign n_eff    = eff_peers(i_cfg.peer_count, CNT_W'(MAX_PEERS));
    assign pk       = r_peer[PW-1:0];
    assign cur_row  = row_of(pk, r_cls);
    assign is_probe = (r_cmd.op == OP_PROBE) || (r_cmd.op == OP_PROBE_ALL);
    assign clr_last = (r_clr == TA_W'(TR_DEPTH-1));
    assign scan_end = CNT_W'(r_peer) >= n_eff;
    assign scan_skip = CNT_W'(r_peer) == CNT_W'(i_cfg.own_rank);
    assign mod_x    = is_probe ? r_in_rd : r_out_rd;
    assign win_d    = r_in_rd - (r_out_rd - 32'(w_eff));
    assign win_fail = (r_cmd.op == OP_RESERVE) && (r_cls == CLS_REQ) &&
                      ((win_d == '0) || win_d[31]);
    assign seq_inc  = r_seq + 32'd1;
    assign tr_hit   = (r_tr_rd == seq_inc);
    assign base     = ((r_cls == CLS_RPC)  ? {w_eff, 1'b0} :
                       (r_cls == CLS_PEER) ? {1'b0, w_eff} : 8'd0) + {1'b0, r_idx};
    assign prod     = 29'(i_cfg.slot_bytes) * 29'(base);

    assign in_raddr  = (r_cmd.op == OP_RESERVE) ? row_of(pk, CLS_PEER) : cur_row;
    assign out_raddr = cur_row;
    assign tr_raddr  = tr_addr(cur_row, r_idx);

    assign o_clearing = (r_state == BS_CLEAR);
    assign o_res      = r_res;

    wms_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_x     (mod_x),
        .i_w     (w_eff),
        .o_done  (rem_done),
        .o_rem   (rem_val)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR: if (clr_last) n_state = BS_IDLE;
            BS_IDLE:  if (!i_cmd_empty) n_state = BS_EXEC;
            BS_EXEC: begin
                case (r_cmd.op)
                    OP_LAND:      n_state = BS_MUL;
                    OP_PROBE_ALL: n_state = BS_SCAN;
                    OP_PROBE, OP_RESERVE, OP_SEND: n_state = BS_RD;
                    default:      n_state = BS_EMIT;
                endcase
            end
            BS_SCAN: begin
                if (scan_end) n_state = BS_EMIT;
                else if (!scan_skip) n_state = BS_RD;
            end
            BS_RD:   n_state = BS_MODS;
            BS_MODS: n_state = win_fail ? BS_EMIT : BS_MODW;
            BS_MODW: if (rem_done) n_state = is_probe ? BS_TRD : BS_MUL;
            BS_TRD:  n_state = BS_TCHK;
            BS_TCHK: begin
                if (tr_hit) n_state = BS_MUL;
                else if (r_cls != CLS_REQ) n_state = BS_RD;
                else if (r_cmd.op == OP_PROBE) n_state = BS_EMIT;
                else n_state = BS_SCAN;
            end
            BS_MUL:  n_state = BS_EMIT;
            BS_EMIT: if (!i_res_full) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_cmd     = r_cmd;
        n_peer    = r_peer;
        n_cls     = r_cls;
        n_seq     = r_seq;
        n_idx     = r_idx;
        n_res     = r_res;
        o_cmd_pop = 1'b0;
        o_res_push = 1'b0;
        rem_start = 1'b0;
        pend_we   = 1'b0;
        tr_we     = 1'b0;
        tr_waddr  = tr_addr(row_of(PW'(r_cmd.peer), r_cmd.cls), CNT_W'(r_cmd.slot));
        tr_wdata  = r_cmd.seq;
        in_we     = 1'b0;
        in_waddr  = cur_row;
        in_wdata  = seq_inc;
        out_we    = 1'b0;
        out_waddr = cur_row;
        out_wdata = seq_inc;
        case (r_state)
            BS_CLEAR: begin
                tr_we    = 1'b1;
                tr_waddr = r_clr;
                tr_wdata = '0;
                if ((TA_W+1)'(r_clr) < (TA_W+1)'(SEQ_DEPTH)) begin
                    in_we     = 1'b1;
                    out_we    = 1'b1;
                    in_waddr  = r_clr[SA_W-1:0];
                    out_waddr = r_clr[SA_W-1:0];
                    in_wdata  = '0;
                    out_wdata = '0;
                end
            end
            BS_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                end
            end
            BS_EXEC: begin
                n_peer = PC_W'(r_cmd.peer);
                n_cls  = r_cmd.cls;
                case (r_cmd.op)
                    OP_LAND: begin
                        tr_we = 1'b1;
                        n_idx = CNT_W'(r_cmd.slot);
                        n_res = '0;
                        n_res.status        = ST_OK;
                        n_res.peer_out      = r_cmd.peer;
                        n_res.class_out     = r_cmd.cls;
                        n_res.trailer_value = r_cmd.seq;
                    end
                    OP_PROBE:     n_cls = CLS_RPC;
                    OP_PROBE_ALL: n_peer = '0;
                    OP_RESERVE:   pend_we = 1'b1;
                    OP_SEND:      n_cls = r_pend[PN_W'(r_cmd.peer)];
                    default:      n_res = fail_res(r_cmd.peer, r_cmd.cls);
                endcase
            end
            BS_SCAN: begin
                if (scan_end) n_res = fail_res(4'd0, CLS_REQ);
                else if (scan_skip) n_peer = r_peer + PC_W'(1);
                else n_cls = CLS_RPC;
            end
            BS_MODS: begin
                if (win_fail) begin
                    n_res = fail_res(4'(r_peer), r_cls);
                end else begin
                    n_seq     = mod_x;
                    rem_start = 1'b1;
                end
            end
            BS_MODW: begin
                if (rem_done) begin
                    n_idx = rem_val;
                    if (!is_probe) begin
                        n_res = '0;
                        n_res.status        = ST_OK;
                        n_res.peer_out      = 4'(r_peer);
                        n_res.class_out     = r_cls;
                        n_res.trailer_value = seq_inc;
                        if (r_cmd.op == OP_SEND) n_res.write_length = i_cfg.slot_bytes;
                    end
                end
            end
            BS_TCHK: begin
                if (tr_hit) begin
                    in_we = 1'b1;
                    n_res = '0;
                    n_res.status        = ST_OK;
                    n_res.peer_out      = 4'(r_peer);
                    n_res.class_out     = r_cls;
                    n_res.trailer_value = seq_inc;
                end else if (r_cls != CLS_REQ) begin
                    n_cls = r_cls - 2'd1;
                end else if (r_cmd.op == OP_PROBE) begin
                    n_res = fail_res(4'(r_peer), CLS_REQ);
                end else begin
                    n_peer = r_peer + PC_W'(1);
                end
            end
            BS_MUL: begin
                n_res.byte_offset = prod[25:0];
                if (r_cmd.op == OP_SEND) out_we = 1'b1;
            end
            BS_EMIT: o_res_push = !i_res_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
            r_clr   <= '0;
            for (int i = 0; i < PEND_N; i++) r_pend[i] <= CLS_REQ;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR && !clr_last) r_clr <= r_clr + TA_W'(1);
            if (pend_we) r_pend[PN_W'(r_cmd.peer)] <= r_cmd.cls;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_peer <= n_peer;
        r_cls  <= n_cls;
        r_seq  <= n_seq;
        r_idx  <= n_idx;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (in_we) r_in_mem[in_waddr] <= in_wdata;
        r_in_rd <= r_in_mem[in_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (out_we) r_out_mem[out_waddr] <= out_wdata;
        r_out_rd <= r_out_mem[out_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tr_we) r_tr_mem[tr_waddr] <= tr_wdata;
        r_tr_rd <= r_tr_mem[tr_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/windowed_mailbox_slot_manager.sv =====
`default_nettype none
// Landed items, reserve refusals and bad items bypass the remainder unit; reserve
// and send run the bit-serial remainder once; a probe runs it once per class
// checked, and probe all runs it once per class and peer.
// The executor handles one item at a time, until its result is queued.
// Reset: pending classes and queues clear; the executor then sweeps the
// trailer store and counters to zero while holding full high.
// ----------------------------------------------------------------------------
// windowed_mailbox_slot_manager
// Per-peer ring mailbox manager with sliding-window sequence numbers.
// ----------------------------------------------------------------------------
module windowed_mailbox_slot_manager #(
    parameter int MAX_PEERS  = 16,
    parameter int MAX_WINDOW = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item input queue side
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_kind,
    input  wire logic [3:0]  i_peer,
    input  wire logic [1:0]  i_msg_class,
    input  wire logic [3:0]  i_slot,
    input  wire logic [31:0] i_seq_value,
    // result queue side
    output logic             empty,
    input  wire logic        pop,
    output logic             o_status,
    output logic [3:0]       o_peer_out,
    output logic [1:0]       o_class_out,
    output logic [25:0]      o_byte_offset,
    output logic [31:0]      o_trailer_value,
    output logic [20:0]      o_write_length,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [20:0] i_cfg_data
);
    import wms_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, back_cmd;
    t_res back_res, out_res;
    logic cmd_full, cmd_empty, cmd_pop;
    logic res_full, res_push, clearing;

    // Registers take writes on any cycle; users write only while idle (unchecked).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_slots <= 5'd8;
            r_cfg.slot_bytes   <= 21'd264;
            r_cfg.own_rank     <= 4'd0;
            r_cfg.peer_count   <= 5'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW: r_cfg.window_slots <= i_cfg_data[4:0];
                CFG_SLOTB:  r_cfg.slot_bytes   <= i_cfg_data;
                CFG_RANK:   r_cfg.own_rank     <= i_cfg_data[3:0];
                CFG_PEERS:  r_cfg.peer_count   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Front: classify each item against the group and window sizes.
    wms_front #(
        .MAX_PEERS  (MAX_PEERS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_cfg       (r_cfg),
        .i_kind      (i_kind),
        .i_peer      (i_peer),
        .i_msg_class (i_msg_class),
        .i_slot      (i_slot),
        .i_seq_value (i_seq_value),
        .o_cmd       (front_cmd)
    );

    // Hold off new items while the stores are being swept after reset.
    assign full = cmd_full || clearing;

    wms_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    // Back: counters, trailer store, probe scan and slot offsets.
    wms_back #(
        .MAX_PEERS  (MAX_PEERS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res),
        .o_clearing  (clearing)
    );

    // Result queue decouples the executor from the consumer.
    wms_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_status        = out_res.status;
    assign o_peer_out      = out_res.peer_out;
    assign o_class_out     = out_res.class_out;
    assign o_byte_offset   = out_res.byte_offset;
    assign o_trailer_value = out_res.trailer_value;
    assign o_write_length  = out_res.write_length;

endmodule
`default_nettype wire
